// File: hdl/cdn_pkg.sv
// ============================================================================
// cdn_pkg - calendar date navigator shared definitions
// Field widths, event codes, reset date, month tables and the small
// date arithmetic helpers used by the navigator datapath.
// ============================================================================
`default_nettype none

package cdn_pkg;

    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int WD_W   = 3;
    localparam int CR_W   = 7;
    localparam int OP_W   = 4;
    localparam int CELL_W = 3;
    localparam int YC_W   = 8;
    localparam int WSUM_W = 15;

    localparam logic [OP_W-1:0] OP_DAY_BACK  = 4'd0;
    localparam logic [OP_W-1:0] OP_DAY_FWD   = 4'd1;
    localparam logic [OP_W-1:0] OP_WEEK_BACK = 4'd2;
    localparam logic [OP_W-1:0] OP_WEEK_FWD  = 4'd3;
    localparam logic [OP_W-1:0] OP_VIEW_PREV = 4'd4;
    localparam logic [OP_W-1:0] OP_VIEW_NEXT = 4'd5;
    localparam logic [OP_W-1:0] OP_PICK      = 4'd6;
    localparam logic [OP_W-1:0] OP_CONFIRM   = 4'd7;
    localparam logic [OP_W-1:0] OP_LOAD      = 4'd8;
    localparam logic [OP_W-1:0] OP_SET_VIEW  = 4'd9;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [MON_W-1:0]  MON_JAN  = 4'd1;
    localparam logic [MON_W-1:0]  MON_MAR  = 4'd3;
    localparam logic [MON_W-1:0]  MON_DEC  = 4'd12;
    localparam logic [CR_W-1:0]   REM_TOP  = 7'd99;
    localparam logic [DAY_W-1:0]  DAY_LEN  = 5'd1;
    localparam logic [DAY_W-1:0]  WEEK_LEN = 5'd7;
    localparam logic [CELL_W-1:0] GRID_ROWS = 3'd6;
    localparam logic [CELL_W-1:0] GRID_COLS = 3'd7;

    // reciprocal of 100: (y * 5243) >> 19 is exact for every 14-bit y
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam int          DIV100_PW    = YEAR_W + 13;

    // year held in binary and as century / year-of-century for the leap rule
    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [CR_W-1:0]   cen;
        logic [CR_W-1:0]   rem;
        logic [MON_W-1:0]  month;
        logic [WD_W-1:0]   fw;
    } ym_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CELL_W-1:0] row;
        logic [CELL_W-1:0] col;
        logic [YEAR_W-1:0] ly;
        logic [MON_W-1:0]  lm;
        logic [DAY_W-1:0]  ld;
    } ev_t;

    // 1 January 2026 is a Thursday
    localparam ym_t RESET_YM = '{year: 14'd2026, cen: 7'd20, rem: 7'd26,
                                 month: 4'd1, fw: 3'd4};

    function automatic logic f_leap(input logic [CR_W-1:0] cen,
                                    input logic [CR_W-1:0] rem);
        logic res;
        if (rem == '0)
            res = (cen[1:0] == 2'd0);
        else
            res = (rem[1:0] == 2'd0);
        return res;
    endfunction

    function automatic logic [DAY_W-1:0] f_month_days(input logic [MON_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] res;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: res = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   res = 5'd30;
            4'd2:                                      res = leap ? 5'd29 : 5'd28;
            default:                                   res = 5'd0;
        endcase
        return res;
    endfunction

    function automatic logic [WD_W-1:0] f_dow_offset(input logic [MON_W-1:0] m);
        logic [WD_W-1:0] res;
        case (m)
            4'd1:    res = 3'd0;
            4'd2:    res = 3'd3;
            4'd3:    res = 3'd2;
            4'd4:    res = 3'd5;
            4'd5:    res = 3'd0;
            4'd6:    res = 3'd3;
            4'd7:    res = 3'd5;
            4'd8:    res = 3'd1;
            4'd9:    res = 3'd4;
            4'd10:   res = 3'd6;
            4'd11:   res = 3'd2;
            4'd12:   res = 3'd4;
            default: res = 3'd0;
        endcase
        return res;
    endfunction

    // 8 = 1 mod 7, so octal digits fold
    function automatic logic [WD_W-1:0] f_mod7(input logic [5:0] a);
        logic [3:0] s;
        s = {1'b0, a[2:0]} + {1'b0, a[5:3]};
        if (s >= 4'd14)
            s = s - 4'd14;
        else if (s >= 4'd7)
            s = s - 4'd7;
        return s[2:0];
    endfunction

    function automatic logic [WD_W-1:0] f_mod7_wide(input logic [WSUM_W-1:0] a);
        logic [5:0] s;
        s = 6'(a[2:0]) + 6'(a[5:3]) + 6'(a[8:6]) + 6'(a[11:9]) + 6'(a[14:12]);
        return f_mod7(s);
    endfunction

    function automatic ym_t f_inc_ym(input ym_t ym);
        ym_t              r;
        logic [DAY_W-1:0] days;
        r    = ym;
        days = f_month_days(ym.month, f_leap(ym.cen, ym.rem));
        if (ym.month < MON_DEC) begin
            r.month = ym.month + 4'd1;
        end
        else begin
            r.month = MON_JAN;
            r.year  = ym.year + 14'd1;
            if (ym.rem == REM_TOP) begin
                r.rem = '0;
                r.cen = ym.cen + 7'd1;
            end
            else begin
                r.rem = ym.rem + 7'd1;
            end
        end
        r.fw = f_mod7(6'(ym.fw) + 6'(days));
        return r;
    endfunction

    function automatic ym_t f_dec_ym(input ym_t ym);
        ym_t              r;
        logic [DAY_W-1:0] days;
        r = ym;
        if (ym.month > MON_JAN) begin
            r.month = ym.month - 4'd1;
        end
        else begin
            r.month = MON_DEC;
            r.year  = ym.year - 14'd1;
            if (ym.rem == '0) begin
                r.rem = REM_TOP;
                r.cen = ym.cen - 7'd1;
            end
            else begin
                r.rem = ym.rem - 7'd1;
            end
        end
        days = f_month_days(r.month, f_leap(r.cen, r.rem));
        r.fw = f_mod7(6'(ym.fw) + 6'd35 - 6'(days));
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/calendar_date_navigator_top.sv
// ============================================================================
// calendar_date_navigator_top - Gregorian date stepper with month view
// Events pass stage registers a, b and c (load-year weekday prep), then the
// update stage, where the date state updates and the result is registered.
// Throughput: one event per cycle when the output is not stalled by out_ready.
// Reset: selection and view return to 1 January 2026, pipeline emptied.
// ============================================================================
`default_nettype none

module calendar_date_navigator_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [cdn_pkg::OP_W-1:0]     opcode,
    input  wire logic [cdn_pkg::CELL_W-1:0]   cell_row,
    input  wire logic [cdn_pkg::CELL_W-1:0]   cell_col,
    input  wire logic [cdn_pkg::YEAR_W-1:0]   load_year,
    input  wire logic [cdn_pkg::MON_W-1:0]    load_month,
    input  wire logic [cdn_pkg::DAY_W-1:0]    load_day,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              accepted,
    output logic                              date_emitted,
    output logic [cdn_pkg::YEAR_W-1:0]        sel_year,
    output logic [cdn_pkg::MON_W-1:0]         sel_month,
    output logic [cdn_pkg::DAY_W-1:0]         sel_day,
    output logic [cdn_pkg::YEAR_W-1:0]        view_year,
    output logic [cdn_pkg::MON_W-1:0]         view_month,
    output logic [cdn_pkg::WD_W-1:0]          view_first_weekday,
    output logic [cdn_pkg::DAY_W-1:0]         view_month_days
);
    import cdn_pkg::*;

    // pipeline registers
    logic              a_vld_reg, b_vld_reg, c_vld_reg, out_valid_reg;
    ev_t               a_ev_reg, b_ev_reg, c_ev_reg;
    logic [YEAR_W-1:0] a_yy_reg, b_yy_reg;
    logic [YC_W-1:0]   b_yc_reg, c_yc_reg;
    logic [CR_W-1:0]   c_yr_reg;
    logic [WSUM_W-1:0] c_wsum_reg;

    // architectural state and result flags
    ym_t               sel_ym_reg, sel_ym_next;
    logic [DAY_W-1:0]  sel_day_reg, sel_day_next;
    ym_t               view_ym_reg, view_ym_next;
    logic              accepted_reg, accepted_next;
    logic              emitted_reg, emitted_next;

    logic take_a, take_b, take_c, take_d;
    logic a_ready, b_ready, c_ready;

    ev_t                 in_ev;
    logic [YEAR_W-1:0]   in_yy;
    logic [DIV100_PW-1:0] div_prod;
    logic [YEAR_W-1:0]   yc_x100, yr_full;
    logic [WSUM_W-1:0]   wsum;

    // -------------------------------------------------------------------
    // handshake
    // -------------------------------------------------------------------
    assign take_d  = c_vld_reg && (!out_valid_reg || out_ready);
    assign c_ready = !c_vld_reg || take_d;
    assign take_c  = b_vld_reg && c_ready;
    assign b_ready = !b_vld_reg || take_c;
    assign take_b  = a_vld_reg && b_ready;
    assign a_ready = !a_vld_reg || take_b;
    assign in_ready = a_ready;
    assign take_a  = in_valid && a_ready;

    // -------------------------------------------------------------------
    // load-year weekday prep: yy, yy / 100, yy % 100 and Sakamoto sum
    // -------------------------------------------------------------------
    assign in_ev = '{op: opcode, row: cell_row, col: cell_col,
                     ly: load_year, lm: load_month, ld: load_day};
    assign in_yy = (load_month < MON_MAR) ? load_year - 14'd1 : load_year;

    assign div_prod = DIV100_PW'(a_yy_reg) * DIV100_PW'(DIV100_MUL);

    assign yc_x100 = YEAR_W'(b_yc_reg) * 14'd100;
    assign yr_full = b_yy_reg - yc_x100;
    assign wsum    = WSUM_W'(b_yy_reg) + WSUM_W'(b_yy_reg >> 2) - WSUM_W'(b_yc_reg)
                   + WSUM_W'(b_yc_reg >> 2) + WSUM_W'(f_dow_offset(b_ev_reg.lm))
                   + 15'd1;

    always_ff @(posedge clk)
    begin
        if (take_a)
        begin
            a_ev_reg <= in_ev;
            a_yy_reg <= in_yy;
        end
        if (take_b)
        begin
            b_ev_reg <= a_ev_reg;
            b_yy_reg <= a_yy_reg;
            b_yc_reg <= div_prod[DIV100_SHIFT +: YC_W];
        end
        if (take_c)
        begin
            c_ev_reg   <= b_ev_reg;
            c_yc_reg   <= b_yc_reg;
            c_yr_reg   <= yr_full[CR_W-1:0];
            c_wsum_reg <= wsum;
        end
    end

    // -------------------------------------------------------------------
    // update stage
    // -------------------------------------------------------------------
    ym_t              ld_ym;
    logic             ld_year_ok, ld_mon_ok, ld_day_ok;
    ym_t              sel_inc, sel_dec, view_inc, view_dec;
    logic             sel_inc_ok, sel_dec_ok, view_inc_ok, view_dec_ok;
    logic [DAY_W-1:0] sel_days, sel_dec_days, view_days, step_len;
    logic [5:0]       fwd_sum, back_sum, grid_idx, cell_off;
    logic             pick_ok;

    always_comb
    begin
        ld_ym.year  = c_ev_reg.ly;
        ld_ym.month = c_ev_reg.lm;
        ld_ym.fw    = f_mod7_wide(c_wsum_reg);
        if (c_ev_reg.lm < MON_MAR && c_yr_reg == REM_TOP)
        begin
            ld_ym.rem = '0;
            ld_ym.cen = CR_W'(c_yc_reg + 8'd1);
        end
        else if (c_ev_reg.lm < MON_MAR)
        begin
            ld_ym.rem = c_yr_reg + 7'd1;
            ld_ym.cen = CR_W'(c_yc_reg);
        end
        else
        begin
            ld_ym.rem = c_yr_reg;
            ld_ym.cen = CR_W'(c_yc_reg);
        end
    end

    assign ld_year_ok = (c_ev_reg.ly >= YEAR_MIN) && (c_ev_reg.ly <= YEAR_MAX);
    assign ld_mon_ok  = (c_ev_reg.lm >= MON_JAN) && (c_ev_reg.lm <= MON_DEC);
    assign ld_day_ok  = (c_ev_reg.ld >= DAY_LEN) &&
                        (c_ev_reg.ld <= f_month_days(c_ev_reg.lm,
                                                     f_leap(ld_ym.cen, ld_ym.rem)));

    assign sel_inc    = f_inc_ym(sel_ym_reg);
    assign sel_dec    = f_dec_ym(sel_ym_reg);
    assign view_inc   = f_inc_ym(view_ym_reg);
    assign view_dec   = f_dec_ym(view_ym_reg);
    assign sel_inc_ok  = (sel_ym_reg.month < MON_DEC) || (sel_ym_reg.year < YEAR_MAX);
    assign sel_dec_ok  = (sel_ym_reg.month > MON_JAN) || (sel_ym_reg.year > YEAR_MIN);
    assign view_inc_ok = (view_ym_reg.month < MON_DEC) || (view_ym_reg.year < YEAR_MAX);
    assign view_dec_ok = (view_ym_reg.month > MON_JAN) || (view_ym_reg.year > YEAR_MIN);

    assign sel_days     = f_month_days(sel_ym_reg.month,
                                       f_leap(sel_ym_reg.cen, sel_ym_reg.rem));
    assign sel_dec_days = f_month_days(sel_dec.month, f_leap(sel_dec.cen, sel_dec.rem));
    assign view_days    = f_month_days(view_ym_reg.month,
                                       f_leap(view_ym_reg.cen, view_ym_reg.rem));

    assign step_len = (c_ev_reg.op == OP_WEEK_BACK || c_ev_reg.op == OP_WEEK_FWD) ?
                      WEEK_LEN : DAY_LEN;
    assign fwd_sum  = 6'(sel_day_reg) + 6'(step_len);
    assign back_sum = 6'(sel_day_reg) + 6'(sel_dec_days) - 6'(step_len);

    assign grid_idx = 6'(c_ev_reg.row) * 6'd7 + 6'(c_ev_reg.col) + 6'd1;
    assign cell_off = grid_idx - 6'(view_ym_reg.fw);
    assign pick_ok  = (c_ev_reg.row < GRID_ROWS) && (c_ev_reg.col < GRID_COLS) &&
                      (grid_idx > 6'(view_ym_reg.fw)) && (cell_off <= 6'(view_days));

    always_comb
    begin
        accepted_next = 1'b0;
        emitted_next  = 1'b0;
        sel_ym_next   = sel_ym_reg;
        sel_day_next  = sel_day_reg;
        view_ym_next  = view_ym_reg;
        case (c_ev_reg.op)
            OP_DAY_BACK, OP_WEEK_BACK:
            begin
                if (sel_day_reg > step_len)
                begin
                    accepted_next = 1'b1;
                    emitted_next  = 1'b1;
                    sel_day_next  = sel_day_reg - step_len;
                    view_ym_next  = sel_ym_reg;
                end
                else if (sel_dec_ok)
                begin
                    accepted_next = 1'b1;
                    emitted_next  = 1'b1;
                    sel_ym_next   = sel_dec;
                    sel_day_next  = back_sum[DAY_W-1:0];
                    view_ym_next  = sel_dec;
                end
            end
            OP_DAY_FWD, OP_WEEK_FWD:
            begin
                if (fwd_sum <= 6'(sel_days))
                begin
                    accepted_next = 1'b1;
                    emitted_next  = 1'b1;
                    sel_day_next  = fwd_sum[DAY_W-1:0];
                    view_ym_next  = sel_ym_reg;
                end
                else if (sel_inc_ok)
                begin
                    accepted_next = 1'b1;
                    emitted_next  = 1'b1;
                    sel_ym_next   = sel_inc;
                    sel_day_next  = DAY_W'(fwd_sum - 6'(sel_days));
                    view_ym_next  = sel_inc;
                end
            end
            OP_VIEW_PREV:
            begin
                if (view_dec_ok)
                begin
                    accepted_next = 1'b1;
                    view_ym_next  = view_dec;
                end
            end
            OP_VIEW_NEXT:
            begin
                if (view_inc_ok)
                begin
                    accepted_next = 1'b1;
                    view_ym_next  = view_inc;
                end
            end
            OP_PICK:
            begin
                if (pick_ok)
                begin
                    accepted_next = 1'b1;
                    emitted_next  = 1'b1;
                    sel_ym_next   = view_ym_reg;
                    sel_day_next  = cell_off[DAY_W-1:0];
                end
            end
            OP_CONFIRM:
            begin
                accepted_next = 1'b1;
                emitted_next  = 1'b1;
            end
            OP_LOAD:
            begin
                if (ld_year_ok && ld_mon_ok && ld_day_ok)
                begin
                    accepted_next = 1'b1;
                    sel_ym_next   = ld_ym;
                    sel_day_next  = c_ev_reg.ld;
                end
            end
            OP_SET_VIEW:
            begin
                if (ld_year_ok && ld_mon_ok)
                begin
                    accepted_next = 1'b1;
                    view_ym_next  = ld_ym;
                end
            end
            default:
            begin
                accepted_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
            emitted_reg   <= 1'b0;
            sel_ym_reg    <= RESET_YM;
            sel_day_reg   <= DAY_LEN;
            view_ym_reg   <= RESET_YM;
        end
        else
        begin
            if (take_a)
                a_vld_reg <= 1'b1;
            else if (take_b)
                a_vld_reg <= 1'b0;
            if (take_b)
                b_vld_reg <= 1'b1;
            else if (take_c)
                b_vld_reg <= 1'b0;
            if (take_c)
                c_vld_reg <= 1'b1;
            else if (take_d)
                c_vld_reg <= 1'b0;
            if (take_d)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (take_d)
            begin
                accepted_reg <= accepted_next;
                emitted_reg  <= emitted_next;
                sel_ym_reg   <= sel_ym_next;
                sel_day_reg  <= sel_day_next;
                view_ym_reg  <= view_ym_next;
            end
        end
    end

    // result beat reads the state left by its event
    assign out_valid          = out_valid_reg;
    assign accepted           = accepted_reg;
    assign date_emitted       = emitted_reg;
    assign sel_year           = sel_ym_reg.year;
    assign sel_month          = sel_ym_reg.month;
    assign sel_day            = sel_day_reg;
    assign view_year          = view_ym_reg.year;
    assign view_month         = view_ym_reg.month;
    assign view_first_weekday = view_ym_reg.fw;
    assign view_month_days    = view_days;

endmodule

`default_nettype wire
